// File: rtl/sm3_pkg.sv
// sm3 package: constants, controller state type, command/status structs, round functions
// no dependencies
`timescale 1ns / 1ps
package sm3_pkg;
    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [255:0] IV = {32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
                                   32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

    typedef enum logic [2:0] {
        ST_IDLE, ST_COMP, ST_PAD, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SRC_DATA, SRC_PAD, SRC_ZERO, SRC_LEN
    } src_t;

    typedef struct packed {
        logic       wr_en;
        src_t       src;
        logic [7:0] data;
        logic       cnt_inc;
        logic       cnt_clr;
        logic       comp_start;
        logic       cv_reset;
    } cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       comp_busy;
    } status_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} << n;
            rotl = d[63:32];
        end
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        p0 = x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        p1 = x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction
endpackage

// File: rtl/sm3_hash_engine_unit.sv
// sm3 hash engine top level: controller plus datapath
// depends on sm3_pkg, sm3_ctrl, sm3_datapath
//
// channel | valid     | ready     | payload
// input   | in_valid  | in_ready  | action, data_byte
// output  | out_valid | out_ready | digest_word, word_index, last_word
//
// an absorb transaction writes one byte; the 64th byte of a block also starts a compression
// (one round per cycle in the datapath round unit); finish writes padding one byte a cycle,
// pausing while a compression runs (at most 72 with the pad byte), with one or two
// compressions, then presents eight words; reset returns the initial vector and zero length
// output stalls hold the digest word and block new input until the last word is taken
`timescale 1ns / 1ps
module sm3_hash_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sm3_pkg::*;

    cmd_t         cmd;
    status_t      status;
    logic [255:0] cv;

    sm3_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .data_byte(data_byte), .out_valid(out_valid),
        .out_ready(out_ready), .digest_word(digest_word), .word_index(word_index),
        .last_word(last_word), .cv(cv), .status(status), .cmd(cmd)
    );

    sm3_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status), .cv(cv)
    );
endmodule

// File: rtl/sm3_datapath.sv
// sm3 datapath: block buffer as 16-word window, byte counter, one-round-per-cycle compression
// depends on sm3_pkg
`timescale 1ns / 1ps
module sm3_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  sm3_pkg::cmd_t    cmd,
    output sm3_pkg::status_t status,
    output logic [255:0]     cv
);
    import sm3_pkg::*;

    logic [511:0] buf_reg, buf_next;
    logic [60:0]  cnt_reg, cnt_next;
    logic [63:0]  len_reg, len_next;
    logic [255:0] cv_reg, cv_next;
    logic [255:0] ws_reg, ws_next;
    logic [6:0]   rnd_reg, rnd_next;
    logic         busy_reg, busy_next;
    logic [5:0]   fill;
    logic [7:0]   wbyte;
    logic [31:0]  a, b, c, d, e, f, g, h, w0, w4, wnew, a12, ss1, ss2, ff, gg, tj;
    logic [5:0]   j;

    assign fill = cnt_reg[5:0];
    assign j = rnd_reg[5:0];
    assign status = '{fill: fill, comp_busy: busy_reg};
    assign cv = cv_reg;
    assign {a, b, c, d, e, f, g, h} = ws_reg;
    assign w0 = buf_reg[511:480];
    assign w4 = buf_reg[383:352];
    assign wnew = p1(buf_reg[511:480] ^ buf_reg[287:256] ^ rotl(buf_reg[95:64], 5'd15))
                  ^ rotl(buf_reg[415:384], 5'd7) ^ buf_reg[191:160];
    assign tj = j[5:4] == 2'd0 ? T_LOW : T_HIGH;
    assign a12 = rotl(a, 5'd12);
    assign ss1 = rotl(a12 + e + rotl(tj, j[4:0]), 5'd7);
    assign ss2 = ss1 ^ a12;
    assign ff = j[5:4] == 2'd0 ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
    assign gg = j[5:4] == 2'd0 ? (e ^ f ^ g) : ((e & f) | (~e & g));

    always_comb
    begin
        case (cmd.src)
            SRC_DATA: wbyte = cmd.data;
            SRC_PAD:  wbyte = PAD_BYTE;
            SRC_ZERO: wbyte = 8'h00;
            SRC_LEN:  wbyte = len_reg[63:56];
            default:  wbyte = 8'h00;
        endcase
    end

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        len_next = len_reg;
        cv_next = cv_reg;
        ws_next = ws_reg;
        rnd_next = rnd_reg;
        busy_next = busy_reg;
        if (cmd.wr_en)
        begin
            buf_next[8 * (63 - fill) +: 8] = wbyte;
            if (cmd.src == SRC_PAD)
                len_next = {cnt_reg, 3'b000};
            else if (cmd.src == SRC_LEN)
                len_next = {len_reg[55:0], 8'h00};
        end
        if (cmd.cnt_clr)
            cnt_next = '0;
        else if (cmd.cnt_inc)
            cnt_next = cnt_reg + 61'd1;
        if (cmd.comp_start)
        begin
            busy_next = 1'b1;
            rnd_next = '0;
            ws_next = cv_reg;
        end
        else if (busy_reg)
        begin
            if (rnd_reg == 7'd64)
            begin
                busy_next = 1'b0;
                cv_next = cv_reg ^ ws_reg;
            end
            else
            begin
                ws_next = {ff + d + ss2 + (w0 ^ w4), a, rotl(b, 5'd9), c,
                           p0(gg + h + ss1 + w0), e, rotl(f, 5'd19), g};
                buf_next = {buf_reg[479:0], wnew};
                rnd_next = rnd_reg + 7'd1;
            end
        end
        if (cmd.cv_reset)
            cv_next = IV;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            cv_reg <= IV;
            rnd_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            cv_reg <= cv_next;
            rnd_reg <= rnd_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        len_reg <= len_next;
        ws_reg <= ws_next;
    end
endmodule

// File: rtl/sm3_ctrl.sv
// sm3 controller: input handshake, padding sequencer, digest word output register
// depends on sm3_pkg
`timescale 1ns / 1ps
module sm3_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             action,
    input  logic [7:0]       data_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word,
    input  logic [255:0]     cv,
    input  sm3_pkg::status_t status,
    output sm3_pkg::cmd_t    cmd
);
    import sm3_pkg::*;

    state_t state_reg, state_next;
    logic   lenph_reg, lenph_next;
    logic   wait_reg, wait_next;
    logic   ov_reg, ov_next;
    logic [2:0] idx_reg, idx_next;
    logic [31:0] dw_reg, dw_next;

    assign out_valid = ov_reg;
    assign digest_word = dw_reg;
    assign word_index = idx_reg;
    assign last_word = idx_reg == 3'd7;
    assign in_ready = state_reg == ST_IDLE && !status.comp_busy && !wait_reg;

    always_comb
    begin
        state_next = state_reg;
        lenph_next = lenph_reg;
        wait_next = 1'b0;
        ov_next = ov_reg;
        idx_next = idx_reg;
        dw_next = dw_reg;
        cmd = '{wr_en: 1'b0, src: SRC_DATA, data: data_byte, cnt_inc: 1'b0,
                cnt_clr: 1'b0, comp_start: 1'b0, cv_reset: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    if (action)
                    begin
                        cmd.src = SRC_PAD;
                        state_next = ST_PAD;
                        lenph_next = 1'b0;
                    end
                    if (status.fill == 6'd63)
                    begin
                        cmd.comp_start = 1'b1;
                        wait_next = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                if (!status.comp_busy && !wait_reg)
                begin
                    cmd.wr_en = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    if (!lenph_reg && status.fill == 6'd56)
                        lenph_next = 1'b1;
                    if (lenph_reg || status.fill == 6'd56)
                        cmd.src = SRC_LEN;
                    else
                        cmd.src = SRC_ZERO;
                    if (status.fill == 6'd63)
                    begin
                        cmd.comp_start = 1'b1;
                        wait_next = 1'b1;
                        if (lenph_reg)
                            state_next = ST_COMP;
                    end
                end
            end
            ST_COMP:
            begin
                if (!status.comp_busy && !wait_reg)
                begin
                    state_next = ST_EMIT;
                    ov_next = 1'b1;
                    idx_next = 3'd0;
                    dw_next = cv[255:224];
                end
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == 3'd7)
                    begin
                        ov_next = 1'b0;
                        state_next = ST_IDLE;
                        cmd.cv_reset = 1'b1;
                        cmd.cnt_clr = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                        dw_next = cv[32 * (6 - idx_reg) +: 32];
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lenph_reg <= 1'b0;
            wait_reg <= 1'b0;
            ov_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lenph_reg <= lenph_next;
            wait_reg <= wait_next;
            ov_reg <= ov_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dw_reg <= dw_next;
    end
endmodule

// File: rtl/sm3_checker.sv
// port-level checks for the sm3 hash engine
// bound to sm3_hash_engine_unit
`timescale 1ns / 1ps
module sm3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  word_index,
    input logic        last_word
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input ready during digest output");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7))) else $error("last_word mismatch");
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=> (out_valid &&
        word_index == $past(word_index) + 3'd1)) else $error("word order broken");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(word_index)))
        else $error("output changed under stall");
endmodule

bind sm3_hash_engine_unit sm3_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .word_index(word_index),
    .last_word(last_word)
);

// File: tb/tb_sm3_hash_engine_unit.sv
// testbench for sm3_hash_engine_unit: byte stream in, eight digest words out
// depends on sm3_pkg and the rtl of sm3_hash_engine_unit; self-checking against an sm3 predictor
`timescale 1ns / 1ps
module tb_sm3_hash_engine_unit;
    import sm3_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_DIRECTED = 10;

    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_txn_t;

    typedef struct {
        logic        action;
        logic [7:0]  data_byte;
        logic        has_word;
        logic [31:0] word0;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        action = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    logic [31:0] cv_model [8];
    logic [7:0]  blk_model [64];
    logic [60:0] len_model;
    digest_txn_t digest_q [$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          hold_off = 0;
    stim_row_t   rows [N_DIRECTED];

    sm3_hash_engine_unit dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] rl(logic [31:0] x, int n);
        logic [63:0] d;
        begin
            d = {x, x} << (n % 32);
            return d[63:32];
        end
    endfunction

    task automatic compress_model();
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;
        begin
            for (int j = 0; j < 16; j++)
                w[j] = {blk_model[4*j], blk_model[4*j+1], blk_model[4*j+2], blk_model[4*j+3]};
            for (int j = 16; j < 68; j++)
            begin
                tj = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
                w[j] = (tj ^ rl(tj, 15) ^ rl(tj, 23)) ^ rl(w[j-13], 7) ^ w[j-6];
            end
            a = cv_model[0]; b = cv_model[1]; c = cv_model[2]; d = cv_model[3];
            e = cv_model[4]; f = cv_model[5]; g = cv_model[6]; h = cv_model[7];
            for (int j = 0; j < 64; j++)
            begin
                tj = (j < 16) ? T_LOW : T_HIGH;
                a12 = rl(a, 12);
                ss1 = rl(a12 + e + rl(tj, j), 7);
                ss2 = ss1 ^ a12;
                if (j < 16)
                begin
                    ffv = a ^ b ^ c;
                    ggv = e ^ f ^ g;
                end
                else
                begin
                    ffv = (a & b) | (a & c) | (b & c);
                    ggv = (e & f) | (~e & g);
                end
                tt1 = ffv + d + ss2 + (w[j] ^ w[j+4]);
                tt2 = ggv + h + ss1 + w[j];
                d = c; c = rl(b, 9); b = a; a = tt1;
                h = g; g = rl(f, 19); f = e;
                e = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
            end
            cv_model[0] ^= a; cv_model[1] ^= b; cv_model[2] ^= c; cv_model[3] ^= d;
            cv_model[4] ^= e; cv_model[5] ^= f; cv_model[6] ^= g; cv_model[7] ^= h;
        end
    endtask

    task automatic reset_model();
        begin
            for (int i = 0; i < 8; i++)
                cv_model[i] = IV[255 - 32*i -: 32];
            len_model = '0;
        end
    endtask

    task automatic predict_hash(logic act, logic [7:0] byte_in);
        int fill;
        logic [63:0] bits;
        digest_txn_t t;
        begin
            fill = int'(len_model[5:0]);
            if (!act)
            begin
                blk_model[fill] = byte_in;
                len_model = len_model + 1'b1;
                if (fill == 63)
                    compress_model();
            end
            else
            begin
                bits = {len_model, 3'b000};
                blk_model[fill] = PAD_BYTE;
                fill++;
                if (fill > 56)
                begin
                    for (int i = fill; i < 64; i++)
                        blk_model[i] = 8'h00;
                    compress_model();
                    fill = 0;
                end
                for (int i = fill; i < 56; i++)
                    blk_model[i] = 8'h00;
                for (int i = 0; i < 8; i++)
                    blk_model[56+i] = bits[63 - 8*i -: 8];
                compress_model();
                for (int i = 0; i < 8; i++)
                begin
                    t.digest_word = cv_model[i];
                    t.word_index = 3'(i);
                    t.last_word = (i == 7);
                    digest_q.push_back(t);
                end
                reset_model();
            end
        end
    endtask

    task automatic send_txn(logic act, logic [7:0] byte_in);
        int gap;
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            action <= act;
            data_byte <= byte_in;
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_hash(act, byte_in);
            @(negedge clk);
        end
    endtask

    task automatic send_message(int len);
        begin
            for (int i = 0; i < len; i++)
                send_txn(1'b0, 8'($urandom));
            send_txn(1'b1, 8'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        digest_txn_t e;
        if (out_valid && out_ready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest word %h", digest_word);
                errors++;
            end
            else
            begin
                e = digest_q.pop_front();
                if (digest_word !== e.digest_word)
                begin
                    $error("digest_word expected %h actual %h", e.digest_word, digest_word);
                    errors++;
                end
                if (word_index !== e.word_index)
                begin
                    $error("word_index expected %0d actual %0d", e.word_index, word_index);
                    errors++;
                end
                if (last_word !== e.last_word)
                begin
                    $error("last_word expected %0d actual %0d", e.last_word, last_word);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** sm3_hash_engine_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else
            begin
                gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
                if (gap == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        int len;
        rows[0] = '{1'b1, 8'h00, 1'b1, 32'h1AB21D83};
        rows[1] = '{1'b0, 8'h61, 1'b0, '0};
        rows[2] = '{1'b0, 8'h62, 1'b0, '0};
        rows[3] = '{1'b0, 8'h63, 1'b0, '0};
        rows[4] = '{1'b1, 8'hFF, 1'b1, 32'h66C7F0F4};
        rows[5] = '{1'b0, 8'hFF, 1'b0, '0};
        rows[6] = '{1'b0, 8'h00, 1'b0, '0};
        rows[7] = '{1'b1, 8'h00, 1'b0, '0};
        rows[8] = '{1'b1, 8'hFF, 1'b0, '0};
        rows[9] = '{1'b1, 8'h5A, 1'b1, 32'h1AB21D83};
        reset_model();
        for (int i = 0; i < 64; i++)
            blk_model[i] = 8'h00;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            send_txn(rows[r].action, rows[r].data_byte);
            if (rows[r].has_word && digest_q.size() >= 8
                && digest_q[digest_q.size()-8].digest_word !== rows[r].word0)
            begin
                $error("digest_word expected %h actual %h", rows[r].word0,
                       digest_q[digest_q.size()-8].digest_word);
                errors++;
            end
        end
        // boundary lengths around the padding split and full blocks
        send_message(55);
        send_message(63);
        send_message(64);
        // long receiver stall so the engine backs up
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            begin
                send_message(2);
                send_message(1);
            end
        join
        for (int m = 0; m < 3; m++)
        begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 4);
            send_message(len);
        end
        in_valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("** sm3_hash_engine_unit: PASSED **");
        else
            $display("** sm3_hash_engine_unit: FAILED **");
        $finish;
    end
endmodule

// File: files.f
rtl/sm3_pkg.sv
rtl/sm3_datapath.sv
rtl/sm3_ctrl.sv
rtl/sm3_hash_engine_unit.sv
rtl/sm3_checker.sv
tb/tb_sm3_hash_engine_unit.sv
